// File: design/blsolv_pkg.sv
// Shared constants, types and helpers for the ballistic launch solver.
// No dependencies; every other design file imports this package.
`default_nettype none
package blsolv_pkg;

  // wide multiplier operand width (split into two halves)
  localparam int MW = 64;
  // square root unit: radicand and root widths
  localparam int SQ_DW = 106;
  localparam int SQ_RW = 53;
  // divider: numerator, divisor and quotient widths
  localparam int DV_NW = 55;
  localparam int DV_DW = 31;
  localparam int DV_QW = 24;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 25;
  localparam logic [CFG_AW-1:0] CFG_SPEED   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_GRAVITY = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_HIGHARC = 2'd2;

  typedef enum logic [1:0] {
    KIND_INVALID,
    KIND_DIRECT,
    KIND_VERT,
    KIND_ARC
  } kind_t;

  // position of the highest set bit of a byte
  function automatic logic [2:0] msb8(input logic [7:0] v);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) p = 3'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// File: design/blsolv_wmul.sv
// 64x64 unsigned multiplier built from four 32x32 partial products; registers the
// partial products, then registers their sum. Depends on blsolv_pkg.
`default_nettype none
module blsolv_wmul import blsolv_pkg::*; (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [MW-1:0]   a,
  input  wire logic [MW-1:0]   b,
  output logic      [2*MW-1:0] p
);
  localparam int H = MW / 2;

  logic [MW-1:0]   p0_r, p1_r, p2_r, p3_r;
  logic [2*MW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= MW'(a[H-1:0]) * MW'(b[H-1:0]);
      p1_r <= MW'(a[H-1:0]) * MW'(b[MW-1:H]);
      p2_r <= MW'(a[MW-1:H]) * MW'(b[H-1:0]);
      p3_r <= MW'(a[MW-1:H]) * MW'(b[MW-1:H]);
      p_r  <= (2*MW)'(p0_r) + ((2*MW)'(p1_r) << H) + ((2*MW)'(p2_r) << H)
            + ((2*MW)'(p3_r) << MW);
    end
  end

  assign p = p_r;
endmodule
`default_nettype wire

// File: design/blsolv_sqrt.sv
// Pipelined integer square root, one root bit per stage (floor result).
// Depends on blsolv_pkg.
`default_nettype none
module blsolv_sqrt import blsolv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [SQ_DW-1:0] v,
  output logic      [SQ_RW-1:0] root
);
  logic [SQ_DW-1:0] rem_r  [SQ_RW];
  logic [SQ_RW-1:0] root_r [SQ_RW];

  genvar k;
  for (k = 0; k < SQ_RW; k++) begin : g_stage
    localparam int B = SQ_RW - 1 - k;
    logic [SQ_DW-1:0] rem_in, t;
    logic [SQ_RW-1:0] root_in;
    if (k == 0) begin : g_first
      assign rem_in  = v;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end
    // (r + 2^b)^2 - r^2
    assign t = (SQ_DW'(root_in) << (B + 1)) | (SQ_DW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= t) begin
          rem_r[k]  <= rem_in - t;
          root_r[k] <= root_in | (SQ_RW'(1) << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  assign root = root_r[SQ_RW-1];
endmodule
`default_nettype wire

// File: design/blsolv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Numerator must be below divisor << DV_QW. Depends on blsolv_pkg.
`default_nettype none
module blsolv_div import blsolv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DV_NW-1:0] num,
  input  wire logic [DV_DW-1:0] den,
  output logic      [DV_QW-1:0] quo
);
  logic [DV_NW-1:0] rem_r [DV_QW];
  logic [DV_DW-1:0] den_r [DV_QW];
  logic [DV_QW-1:0] quo_r [DV_QW];

  genvar k;
  for (k = 0; k < DV_QW; k++) begin : g_stage
    localparam int B = DV_QW - 1 - k;
    logic [DV_NW-1:0] rem_in, t;
    logic [DV_DW-1:0] den_in;
    logic [DV_QW-1:0] quo_in;
    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end
    assign t = DV_NW'(den_in) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        if (rem_in >= t) begin
          rem_r[k] <= rem_in - t;
          quo_r[k] <= quo_in | (DV_QW'(1) << B);
        end else begin
          rem_r[k] <= rem_in;
          quo_r[k] <= quo_in;
        end
      end
    end
  end

  assign quo = quo_r[DV_QW-1];
endmodule
`default_nettype wire

// File: design/ballistic_launch_solver.sv
// Ballistic launch solver top level: config registers and the solve pipeline.
// Depends on blsolv_pkg, blsolv_wmul, blsolv_sqrt and blsolv_div.
//
// Takes one word per cycle unless the pipeline holds, and returns one result
// word per input word, in order. The pipeline has seven front stages (wide
// products and the discriminant), a 53-stage square root of the
// discriminant, seven stages of direction forming and normalization, a
// second 53-stage square root for the vector length, one scaling stage, a
// 24-stage divider and the output register. The whole pipeline holds while a
// result word waits at the output. Configuration writes also affect words
// already in flight; there is no clearing pass after reset.
`default_nettype none
module ballistic_launch_solver import blsolv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // tdata: start_x, start_y, start_z, aim_x, aim_y, aim_z (32 bits each)
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [191:0]      in_tdata,
  // tdata: vel_x, vel_y, vel_z (32 bits each)
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [95:0]       out_tdata,
  // tuser: solved
  output logic      [0:0]        out_tuser,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  typedef struct packed {
    logic               vld;
    kind_t              kind;
    logic signed [32:0] dx, dy, dz;
    logic [56:0]        gx, gy, gz;
  } fr_t;

  typedef struct packed {
    logic        vld;
    kind_t       kind;
    logic [2:0]  sgn;
    logic [56:0] u0, u1, u2;
  } nm_t;

  typedef struct packed {
    logic        vld;
    kind_t       kind;
    logic [2:0]  sgn;
    logic [29:0] u0, u1, u2;
  } sc_t;

  // configuration
  logic [23:0] speed_r;
  logic [24:0] grav_r;
  logic        high_arc_r;
  logic [24:0] gmag_r;
  logic [47:0] s2_r;
  logic [2*MW-1:0] s4;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r    <= '0;
      grav_r     <= '0;
      high_arc_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_SPEED:   speed_r    <= cfg_data[23:0];
        CFG_GRAVITY: grav_r     <= cfg_data;
        CFG_HIGHARC: high_arc_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    gmag_r <= grav_r[24] ? (25'h1000000 - {1'b0, grav_r[23:0]}) : {1'b0, grav_r[23:0]};
    s2_r   <= 48'(speed_r) * 48'(speed_r);
  end

  blsolv_wmul u_s4 (.clk(clk), .en(1'b1), .a(MW'(s2_r)), .b(MW'(s2_r)), .p(s4));

  logic en;
  logic p_vld_r;
  assign en        = !p_vld_r || out_tready;
  assign in_tready = en;

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // stage A: differences
  logic               a_vld_r;
  logic signed [32:0] a_dx_r, a_dy_r, a_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_tvalid;
    if (en) begin
      a_dx_r <= $signed({in_tdata[127], in_tdata[127:96]}) - $signed({in_tdata[31], in_tdata[31:0]});
      a_dy_r <= $signed({in_tdata[159], in_tdata[159:128]})
              - $signed({in_tdata[63], in_tdata[63:32]});
      a_dz_r <= $signed({in_tdata[191], in_tdata[191:160]})
              - $signed({in_tdata[95], in_tdata[95:64]});
    end
  end

  // stage B: case split and g*|d|
  fr_t b_nxt, b_r, c_r, d_r, e_r, f_r, g_r;

  always_comb begin
    b_nxt.vld = a_vld_r;
    b_nxt.dx  = a_dx_r;
    b_nxt.dy  = a_dy_r;
    b_nxt.dz  = a_dz_r;
    b_nxt.gx  = 57'(gmag_r) * 57'(abs33(a_dx_r));
    b_nxt.gy  = 57'(gmag_r) * 57'(abs33(a_dy_r));
    b_nxt.gz  = 57'(gmag_r) * 57'(abs33(a_dz_r));
    if (speed_r == '0 || (a_dx_r == '0 && a_dy_r == '0 && a_dz_r == '0))
      b_nxt.kind = KIND_INVALID;
    else if (gmag_r == '0)
      b_nxt.kind = KIND_DIRECT;
    else if (a_dx_r == '0 && a_dy_r == '0)
      b_nxt.kind = KIND_VERT;
    else
      b_nxt.kind = KIND_ARC;
  end

  logic [2*MW-1:0] pgx, pgy, pgz;
  blsolv_wmul u_gx (.clk(clk), .en(en), .a(MW'(b_r.gx)), .b(MW'(b_r.gx)), .p(pgx));
  blsolv_wmul u_gy (.clk(clk), .en(en), .a(MW'(b_r.gy)), .b(MW'(b_r.gy)), .p(pgy));
  blsolv_wmul u_gz (.clk(clk), .en(en), .a(MW'(b_r.gz)), .b(MW'(s2_r)), .p(pgz));

  // stages E..G: discriminant
  fr_t e_nxt, g_nxt;
  logic [115:0]     e_sxy_r;
  logic [105:0]     e_rise_r;
  logic [106:0]     f_pos_r;
  logic [116:0]     f_neg_r;
  logic [SQ_DW-1:0] g_dval_r;

  always_comb begin
    e_nxt = d_r;
    if (d_r.kind == KIND_VERT && !d_r.dz[32] && (58'(d_r.gz) << 1) > 58'(s2_r))
      e_nxt.kind = KIND_INVALID;
    g_nxt = f_r;
    if (f_r.kind == KIND_ARC && 117'(f_pos_r) < f_neg_r)
      g_nxt.kind = KIND_INVALID;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0; c_r <= '0; d_r <= '0; e_r <= '0; f_r <= '0; g_r <= '0;
    end else if (en) begin
      b_r <= b_nxt; c_r <= b_r; d_r <= c_r; e_r <= e_nxt; f_r <= e_r; g_r <= g_nxt;
    end
    if (en) begin
      e_sxy_r  <= 116'(pgx) + 116'(pgy);
      e_rise_r <= 106'(pgz) << 1;
      f_pos_r  <= 107'(s4[95:0]) + (e_r.dz[32] ? 107'(e_rise_r) : 107'(0));
      f_neg_r  <= 117'(e_sxy_r) + (e_r.dz[32] ? 117'(0) : 117'(e_rise_r));
      g_dval_r <= SQ_DW'(117'(f_pos_r) - f_neg_r);
    end
  end

  logic [SQ_RW-1:0] root1;
  fr_t sq1_r [SQ_RW];
  blsolv_sqrt u_sqrt1 (.clk(clk), .en(en), .v(g_dval_r), .root(root1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ_RW; i++) sq1_r[i] <= '0;
    end else if (en) begin
      sq1_r[0] <= g_r;
      for (int i = 1; i < SQ_RW; i++) sq1_r[i] <= sq1_r[i-1];
    end
  end

  // stage H: direction magnitudes and signs
  fr_t  hq;
  nm_t  h_nxt, h_r, i_r, j_r, k_r;
  logic [53:0] s2e, rte;

  assign hq  = sq1_r[SQ_RW-1];
  assign s2e = 54'(s2_r);
  assign rte = 54'(root1);

  always_comb begin
    h_nxt.vld  = hq.vld;
    h_nxt.kind = hq.kind;
    h_nxt.sgn  = {hq.dz[32], hq.dy[32], hq.dx[32]};
    h_nxt.u0   = '0;
    h_nxt.u1   = '0;
    h_nxt.u2   = '0;
    case (hq.kind)
      KIND_DIRECT: begin
        h_nxt.u0 = 57'(abs33(hq.dx));
        h_nxt.u1 = 57'(abs33(hq.dy));
        h_nxt.u2 = 57'(abs33(hq.dz));
      end
      KIND_ARC: begin
        h_nxt.u0 = hq.gx;
        h_nxt.u1 = hq.gy;
        if (high_arc_r) begin
          h_nxt.u2     = 57'(s2e + rte);
          h_nxt.sgn[2] = 1'b0;
        end else if (rte > s2e) begin
          h_nxt.u2     = 57'(rte - s2e);
          h_nxt.sgn[2] = 1'b1;
        end else begin
          h_nxt.u2     = 57'(s2e - rte);
          h_nxt.sgn[2] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // stages I..K: largest magnitude and its leading bit position
  logic [56:0] i_m_r;
  logic [63:0] m64;
  logic [7:0]  j_nz_r;
  logic [2:0]  j_loc_r [8];
  logic [5:0]  k_p_nxt, k_p_r;

  assign m64 = 64'(i_m_r);

  always_comb begin
    k_p_nxt = '0;
    for (int g = 0; g < 8; g++) begin
      if (j_nz_r[g]) k_p_nxt = {3'(g), j_loc_r[g]};
    end
  end

  // stage L: common shift to put the largest in [2^29, 2^30)
  sc_t l_nxt, l_r, m_r, n_r;

  function automatic logic [29:0] norm(input logic [56:0] u, input logic [5:0] p);
    if (p >= 6'd29) return 30'(u >> (p - 6'd29));
    else return 30'(u << (6'd29 - p));
  endfunction

  always_comb begin
    l_nxt.vld  = k_r.vld;
    l_nxt.kind = k_r.kind;
    l_nxt.sgn  = k_r.sgn;
    l_nxt.u0   = norm(k_r.u0, k_p_r);
    l_nxt.u1   = norm(k_r.u1, k_p_r);
    l_nxt.u2   = norm(k_r.u2, k_p_r);
  end

  logic [59:0] m_sq0_r, m_sq1_r, m_sq2_r;
  logic [61:0] n_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0; i_r <= '0; j_r <= '0; k_r <= '0;
      l_r <= '0; m_r <= '0; n_r <= '0;
    end else if (en) begin
      h_r <= h_nxt; i_r <= h_r; j_r <= i_r; k_r <= j_r;
      l_r <= l_nxt; m_r <= l_r; n_r <= m_r;
    end
    if (en) begin
      i_m_r <= (h_r.u0 >= h_r.u1)
             ? ((h_r.u0 >= h_r.u2) ? h_r.u0 : h_r.u2)
             : ((h_r.u1 >= h_r.u2) ? h_r.u1 : h_r.u2);
      for (int g = 0; g < 8; g++) begin
        j_nz_r[g]  <= |m64[8*g +: 8];
        j_loc_r[g] <= msb8(m64[8*g +: 8]);
      end
      k_p_r   <= k_p_nxt;
      m_sq0_r <= 60'(l_r.u0) * 60'(l_r.u0);
      m_sq1_r <= 60'(l_r.u1) * 60'(l_r.u1);
      m_sq2_r <= 60'(l_r.u2) * 60'(l_r.u2);
      n_sum_r <= 62'(m_sq0_r) + 62'(m_sq1_r) + 62'(m_sq2_r);
    end
  end

  logic [SQ_RW-1:0] root2;
  sc_t sq2_r [SQ_RW];
  blsolv_sqrt u_sqrt2 (.clk(clk), .en(en), .v(SQ_DW'(n_sum_r)), .root(root2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ_RW; i++) sq2_r[i] <= '0;
    end else if (en) begin
      sq2_r[0] <= n_r;
      for (int i = 1; i < SQ_RW; i++) sq2_r[i] <= sq2_r[i-1];
    end
  end

  // stage O: speed * u + len/2, rounding half away from zero
  sc_t              oq, o_r;
  logic [DV_DW-1:0] len, o_len_r;
  logic [DV_NW-1:0] o_num0_r, o_num1_r, o_num2_r;

  assign oq  = sq2_r[SQ_RW-1];
  assign len = root2[DV_DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) o_r <= '0;
    else if (en) o_r <= oq;
    if (en) begin
      o_len_r  <= len;
      o_num0_r <= DV_NW'(speed_r) * DV_NW'(oq.u0) + DV_NW'(len >> 1);
      o_num1_r <= DV_NW'(speed_r) * DV_NW'(oq.u1) + DV_NW'(len >> 1);
      o_num2_r <= DV_NW'(speed_r) * DV_NW'(oq.u2) + DV_NW'(len >> 1);
    end
  end

  logic [DV_QW-1:0] q0, q1, q2;
  sc_t dv_r [DV_QW];
  blsolv_div u_div0 (.clk(clk), .en(en), .num(o_num0_r), .den(o_len_r), .quo(q0));
  blsolv_div u_div1 (.clk(clk), .en(en), .num(o_num1_r), .den(o_len_r), .quo(q1));
  blsolv_div u_div2 (.clk(clk), .en(en), .num(o_num2_r), .den(o_len_r), .quo(q2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DV_QW; i++) dv_r[i] <= '0;
    end else if (en) begin
      dv_r[0] <= o_r;
      for (int i = 1; i < DV_QW; i++) dv_r[i] <= dv_r[i-1];
    end
  end

  // stage P: output word
  sc_t         pq;
  logic [31:0] vel0_nxt, vel1_nxt, vel2_nxt;
  logic        solved_nxt;
  logic [31:0] p_vel0_r, p_vel1_r, p_vel2_r;
  logic        p_solved_r;

  assign pq = dv_r[DV_QW-1];

  always_comb begin
    vel0_nxt   = '0;
    vel1_nxt   = '0;
    vel2_nxt   = '0;
    solved_nxt = 1'b0;
    case (pq.kind)
      KIND_VERT: begin
        vel2_nxt   = pq.sgn[2] ? -32'(speed_r) : 32'(speed_r);
        solved_nxt = 1'b1;
      end
      KIND_DIRECT, KIND_ARC: begin
        if (q0 != '0 || q1 != '0 || q2 != '0) begin
          vel0_nxt   = pq.sgn[0] ? -32'(q0) : 32'(q0);
          vel1_nxt   = pq.sgn[1] ? -32'(q1) : 32'(q1);
          vel2_nxt   = pq.sgn[2] ? -32'(q2) : 32'(q2);
          solved_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else if (en) p_vld_r <= pq.vld;
    if (en) begin
      p_vel0_r   <= vel0_nxt;
      p_vel1_r   <= vel1_nxt;
      p_vel2_r   <= vel2_nxt;
      p_solved_r <= solved_nxt;
    end
  end

  assign out_tvalid = p_vld_r;
  assign out_tdata  = {p_vel2_r, p_vel1_r, p_vel0_r};
  assign out_tuser  = p_solved_r;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Testbench for ballistic_launch_solver: random and directed launch problems,
// predicted in place and checked word by word. Depends on blsolv_pkg.
`timescale 1ns / 1ps

class launch_scoreboard;
  logic [23:0]  speed;
  logic [24:0]  gravity;
  logic         high_arc;
  logic [96:0]  pending[$];
  int           errors;

  function new();
    speed = '0;
    gravity = '0;
    high_arc = 1'b0;
    errors = 0;
  endfunction

  static function logic [63:0] mag(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  static function logic [63:0] isqrt(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  // speed times unit direction; bit 96 set when nonzero
  function logic [96:0] scale_dir(input logic signed [63:0] wx, input logic signed [63:0] wy,
                                  input logic signed [63:0] wz);
    logic [63:0] u[3];
    logic signed [63:0] w[3];
    logic [63:0] m, sum, len, q;
    logic [96:0] res;
    w[0] = wx; w[1] = wy; w[2] = wz;
    m = 0; sum = 0; res = '0;
    for (int i = 0; i < 3; i++) begin
      u[i] = mag(w[i]);
      if (u[i] > m) m = u[i];
    end
    if (m == 0) return '0;
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) u[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) u[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += u[i] * u[i];
    len = isqrt({64'd0, sum});
    if (len == 0) return '0;
    for (int i = 0; i < 3; i++) begin
      q = ({40'd0, speed} * u[i] + len / 2) / len;
      if (q != 0) res[96] = 1'b1;
      res[32*i +: 32] = w[i] < 0 ? -q[31:0] : q[31:0];
    end
    return res[96] ? res : '0;
  endfunction

  function void note_launch(input logic [191:0] d);
    logic signed [63:0] dx, dy, dz, s2, rt;
    logic [63:0] g, gx, gy, gz;
    logic [127:0] pos, neg, rise;
    logic [96:0] res;
    dx = 64'(signed'(d[127:96])) - 64'(signed'(d[31:0]));
    dy = 64'(signed'(d[159:128])) - 64'(signed'(d[63:32]));
    dz = 64'(signed'(d[191:160])) - 64'(signed'(d[95:64]));
    g = gravity[24] ? 64'h1000000 - gravity[23:0] : gravity[23:0];
    s2 = speed * speed;
    res = '0;
    if (speed == 0 || (dx == 0 && dy == 0 && dz == 0)) res = '0;
    else if (g == 0) res = scale_dir(dx, dy, dz);
    else if (dx == 0 && dy == 0) begin
      if (!(dz > 0 && 2 * g * dz > s2)) begin
        res[95:64] = dz < 0 ? -{8'd0, speed} : {8'd0, speed};
        res[96] = 1'b1;
      end
    end else begin
      gx = g * mag(dx); gy = g * mag(dy); gz = g * mag(dz);
      pos = {64'd0, s2} * s2;
      neg = {64'd0, gx} * gx + {64'd0, gy} * gy;
      rise = 2 * ({64'd0, gz} * s2);
      if (dz < 0) pos += rise;
      else neg += rise;
      if (pos >= neg) begin
        rt = isqrt(pos - neg);
        res = scale_dir(g * dx, g * dy, high_arc ? s2 + rt : s2 - rt);
      end
    end
    pending.push_back(res);
  endfunction

  function void check_velocity(input logic [95:0] d, input logic solved);
    logic [96:0] e;
    if (pending.size() == 0) begin
      report("result word with nothing expected");
      return;
    end
    e = pending.pop_front();
    for (int i = 0; i < 3; i++)
      if (d[32*i +: 32] !== e[32*i +: 32])
        report($sformatf("vel[%0d] got %h want %h", i, d[32*i +: 32], e[32*i +: 32]));
    if (solved !== e[96]) report($sformatf("solved got %b want %b", solved, e[96]));
  endfunction

  function void report(input string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH: %s", msg);
  endfunction
endclass

module testbench import blsolv_pkg::*;;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [191:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0;
  logic [95:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  longint cycles = 0;
  launch_scoreboard sb = new();

  ballistic_launch_solver i_dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("testbench failed");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) sb.note_launch(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_velocity(out_tdata, out_tuser[0]);
  end

  // receiver stalls; a quiet stretch in the middle
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (cycles > 60000 && cycles < 70000) out_tready <= 1;
      else begin
        g = gap_len();
        if (g > 0) begin
          out_tready <= 0;
          repeat (g) @(negedge clk);
        end
        out_tready <= 1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] v);
    @(negedge clk);
    cfg_valid <= 1; cfg_addr <= a; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (a)
      CFG_SPEED:   sb.speed = v[23:0];
      CFG_GRAVITY: sb.gravity = v;
      default:     sb.high_arc = v[0];
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_launch(input logic [31:0] p[6]);
    int g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {p[5], p[4], p[3], p[2], p[1], p[0]};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($urandom_range(0, 4000)) - 32'd2000;
      default: return 32'($urandom_range(0, 200000)) - 32'd100000;
    endcase
  endfunction

  initial begin
    logic [31:0] p[6];
    logic [31:0] ext[4];
    int mode;
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // all-zero registers: speed zero means invalid
    p = '{32'd0, 32'd0, 32'd0, 32'd256, 32'd0, 32'd0};
    send_launch(p);
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(CFG_SPEED, 25'd2560); write_reg(CFG_GRAVITY, -25'sd2509);
                 write_reg(CFG_HIGHARC, 25'd0); end
        1: write_reg(CFG_HIGHARC, 25'd1);
        2: write_reg(CFG_GRAVITY, 25'd0);
        3: begin write_reg(CFG_SPEED, 25'hffffff); write_reg(CFG_GRAVITY, 25'h1000001); end
        4: begin write_reg(CFG_SPEED, 25'd1); write_reg(CFG_GRAVITY, 25'hffffff);
                 write_reg(CFG_HIGHARC, 25'd0); end
        default: begin write_reg(CFG_SPEED, 25'($urandom_range(1, 40000)));
                       write_reg(CFG_GRAVITY, 25'($urandom_range(0, 33554431)));
                       write_reg(CFG_HIGHARC, 25'($urandom_range(0, 1))); end
      endcase
      if (phase == 0) begin
        // directed: coincident, vertical up/down, too high, horizontal near/far, extremes
        p = '{32'd5, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5}; send_launch(p);
        p = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd2560}; send_launch(p);
        p = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, -32'd2560}; send_launch(p);
        p = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd900000}; send_launch(p);
        p = '{32'd0, 32'd0, 32'd0, 32'd2560, 32'd0, 32'd0}; send_launch(p);
        p = '{32'd0, 32'd0, 32'd0, 32'd9000000, 32'd0, 32'd0}; send_launch(p);
        for (int i = 0; i < 16; i++) begin
          for (int k = 0; k < 6; k++) p[k] = ext[(i + k * (i / 4 + 1)) % 4];
          send_launch(p);
        end
      end
      for (int n = 0; n < 190; n++) begin
        mode = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 2);
        for (int k = 0; k < 6; k++) p[k] = rnd_coord(mode);
        if ($urandom_range(0, 9) == 0) begin p[3] = p[0]; p[4] = p[1]; end
        send_launch(p);
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
